// ----- rtl/vam_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vam_pkg: shared types and constants for vector angle and magnitude
// CORDIC arctangent table, angle constants and pipeline word layouts.
// ----------------------------------------------------------------------------
package vam_pkg;

	localparam int XW = 34;

	localparam logic [32:0] PI_Q30      = 33'd3373259426;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
	localparam logic [28:0] DEG_SCALE   = 29'd480631834;
	localparam logic [16:0] FULL_RAD    = 17'd51472;
	localparam logic [16:0] FULL_DEG    = 17'd46080;
	localparam logic [15:0] MAG_MAX     = 16'd46341;
	localparam int SQRT_STEPS_PER_STAGE = 2;
	localparam int SQRT_STAGES          = 8;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic xzero;
		logic yzero;
	} quad_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [31:0]   z;
		sq_t                  sq;
		quad_t                quad;
	} cord_t;

	function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:    v = 32'sh3243F6A8;
			5'd1:    v = 32'sh1DAC6705;
			5'd2:    v = 32'sh0FADBAFC;
			5'd3:    v = 32'sh07F56EA6;
			5'd4:    v = 32'sh03FEAB76;
			5'd5:    v = 32'sh01FFD55B;
			5'd6:    v = 32'sh00FFFAAA;
			5'd7:    v = 32'sh007FFF55;
			5'd8:    v = 32'sh003FFFEA;
			5'd9:    v = 32'sh001FFFFD;
			5'd10:   v = 32'sh000FFFFF;
			5'd11:   v = 32'sh0007FFFF;
			5'd12:   v = 32'sh0003FFFF;
			5'd13:   v = 32'sh0001FFFF;
			5'd14:   v = 32'sh0000FFFF;
			5'd15:   v = 32'sh00007FFF;
			5'd16:   v = 32'sh00003FFF;
			5'd17:   v = 32'sh00001FFF;
			5'd18:   v = 32'sh00000FFF;
			5'd19:   v = 32'sh000007FF;
			5'd20:   v = 32'sh000003FF;
			5'd21:   v = 32'sh000001FF;
			5'd22:   v = 32'sh000000FF;
			5'd23:   v = 32'sh0000007F;
			default: v = 32'sh00000000;
		endcase
		return v;
	endfunction

	// one digit of the bit-by-bit square root
	function automatic sq_t sqrt_step(input sq_t s, input logic [31:0] bitv);
		sq_t         r;
		logic [32:0] rb;
		rb = {1'b0, s.root} + {1'b0, bitv};
		if ({1'b0, s.rem} >= rb) begin
			r.rem  = s.rem - rb[31:0];
			r.root = (s.root >> 1) + bitv;
		end else begin
			r.rem  = s.rem;
			r.root = s.root >> 1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/vector_angle_and_magnitude.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle while res_stall is low; one CORDIC micro-rotation per stage.
// Stages without a valid word fill up while the output is stalled.
// Reset clears all valid bits and the degree register; data is not reset.
// ----------------------------------------------------------------------------
// vector_angle_and_magnitude: pipelined atan2 and vector length
// Angle in radians or degrees over [0, 2pi), rounded integer magnitude.
// ----------------------------------------------------------------------------
module vector_angle_and_magnitude #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write_en,
	input  wire logic               cfg_write_data,
	input  wire logic               vec_valid,
	output logic                    vec_stall,
	input  wire logic signed [15:0] x_coord,
	input  wire logic signed [15:0] y_coord,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [15:0]             angle,
	output logic [15:0]             magnitude
);

	localparam int L = CORDIC_STAGES + 6;

	logic           deg_q;
	logic [L-1:0]   v_q;
	logic [L:0]     rdy;
	vam_pkg::cord_t chain [0:CORDIC_STAGES];

	assign rdy[L]    = ~res_stall;
	assign vec_stall = ~rdy[0];
	assign res_valid = v_q[L-1];

	genvar k;
	generate
		for (k = 0; k < L; k++) begin : g_rdy
			assign rdy[k] = ~v_q[k] | rdy[k+1];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b0;
		end else if (cfg_write_en) begin
			deg_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < L; i++) begin
				if (rdy[i]) begin
					v_q[i] <= (i == 0) ? vec_valid : v_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	vam_front u_front (
		.clk     (clk),
		.en      (rdy[2:0]),
		.x_coord (x_coord),
		.y_coord (y_coord),
		.cord_s3 (chain[0])
	);

	generate
		for (k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
			vam_cordic_stage #(
				.STAGE (k)
			) u_stage (
				.clk    (clk),
				.en     (rdy[3+k]),
				.d      (chain[k]),
				.cord_s (chain[k+1])
			);
		end
	endgenerate

	vam_back u_back (
		.clk      (clk),
		.en       (rdy[L-1:L-3]),
		.deg      (deg_q),
		.d        (chain[CORDIC_STAGES]),
		.angle_s3 (angle),
		.mag_s3   (magnitude)
	);

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		vec_stall |-> res_valid)
		else $error("input stalled with an output stage free");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!res_stall |-> !vec_stall)
		else $error("input stalled while output drains");

	a_rad_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, angle} < vam_pkg::FULL_RAD))
		else $error("angle beyond full circle");

	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && deg_q) |-> ({1'b0, angle} < vam_pkg::FULL_DEG))
		else $error("degree angle beyond full circle");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (magnitude <= vam_pkg::MAG_MAX))
		else $error("magnitude out of range");

endmodule
`default_nettype wire

// ----- rtl/vam_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vam_front: input stages
// Absolute values and axis flags, squares, then the CORDIC and root seed.
// ----------------------------------------------------------------------------
module vam_front (
	input  wire logic               clk,
	input  wire logic [2:0]         en,
	input  wire logic signed [15:0] x_coord,
	input  wire logic signed [15:0] y_coord,
	output vam_pkg::cord_t          cord_s3
);

	logic signed [16:0] xe;
	logic signed [16:0] ye;
	logic [16:0]        ax_s1;
	logic [16:0]        ay_s1;
	vam_pkg::quad_t     quad_s1;
	logic [16:0]        ax_s2;
	logic [16:0]        ay_s2;
	logic [30:0]        sqx_s2;
	logic [30:0]        sqy_s2;
	vam_pkg::quad_t     quad_s2;
	logic [33:0]        px;
	logic [33:0]        py;

	assign xe = {x_coord[15], x_coord};
	assign ye = {y_coord[15], y_coord};
	assign px = ax_s1 * ax_s1;
	assign py = ay_s1 * ay_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ax_s1         <= xe[16] ? 17'(-xe) : 17'(xe);
			ay_s1         <= ye[16] ? 17'(-ye) : 17'(ye);
			quad_s1.xneg  <= x_coord[15];
			quad_s1.yneg  <= y_coord[15];
			quad_s1.xzero <= (x_coord == 16'sd0);
			quad_s1.yzero <= (y_coord == 16'sd0);
		end
		if (en[1]) begin
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			sqx_s2  <= px[30:0];
			sqy_s2  <= py[30:0];
			quad_s2 <= quad_s1;
		end
		if (en[2]) begin
			cord_s3.x       <= $signed({1'b0, ax_s2, 16'b0});
			cord_s3.y       <= $signed({1'b0, ay_s2, 16'b0});
			cord_s3.z       <= 32'sd0;
			cord_s3.sq.rem  <= 32'(sqx_s2) + 32'(sqy_s2);
			cord_s3.sq.root <= 32'd0;
			cord_s3.quad    <= quad_s2;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/vam_cordic_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vam_cordic_stage: one vectoring micro-rotation
// Early stages also resolve two digits of the square root.
// ----------------------------------------------------------------------------
module vam_cordic_stage #(
	parameter int STAGE = 0
) (
	input  wire logic     clk,
	input  wire logic     en,
	input  wire vam_pkg::cord_t d,
	output vam_pkg::cord_t cord_s
);

	logic signed [vam_pkg::XW-1:0] xs;
	logic signed [vam_pkg::XW-1:0] ys;
	logic signed [vam_pkg::XW-1:0] xv;
	logic signed [vam_pkg::XW-1:0] yv;
	logic signed [31:0]            at;
	vam_pkg::sq_t                  sq_n;

	assign xv = d.x;
	assign yv = d.y;
	assign xs = xv >>> STAGE;
	assign ys = yv >>> STAGE;
	assign at = vam_pkg::atan_q30(5'(STAGE));

	generate
		if (STAGE < vam_pkg::SQRT_STAGES) begin : g_root
			localparam int J = STAGE * vam_pkg::SQRT_STEPS_PER_STAGE;
			vam_pkg::sq_t mid;
			assign mid  = vam_pkg::sqrt_step(d.sq, 32'd1 << (30 - 2 * J));
			assign sq_n = vam_pkg::sqrt_step(mid, 32'd1 << (28 - 2 * J));
		end else begin : g_hold
			assign sq_n = d.sq;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			if (!yv[vam_pkg::XW-1]) begin
				cord_s.x <= xv + ys;
				cord_s.y <= yv - xs;
				cord_s.z <= d.z + at;
			end else begin
				cord_s.x <= xv - ys;
				cord_s.y <= yv + xs;
				cord_s.z <= d.z - at;
			end
			cord_s.sq   <= sq_n;
			cord_s.quad <= d.quad;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/vam_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vam_back: output stages
// Quadrant restore, root rounding, unit conversion and full-circle wrap.
// ----------------------------------------------------------------------------
module vam_back (
	input  wire logic       clk,
	input  wire logic [2:0] en,
	input  wire logic       deg,
	input  wire vam_pkg::cord_t d,
	output logic [15:0]     angle_s3,
	output logic [15:0]     mag_s3
);

	logic [30:0] phi;
	logic [32:0] a_full;
	logic [32:0] a_s1;
	logic [15:0] mag_s1;
	logic [15:0] mag_s2;
	logic [15:0] rad_s2;
	logic [44:0] ph_s2;
	logic [45:0] pl_s2;
	logic [33:0] rsum;
	logic [16:0] r17;
	logic [62:0] tot;
	logic [16:0] d17;
	logic [15:0] deg_v;

	always_comb begin
		if (d.z[31]) begin
			phi = 31'd0;
		end else if (d.z[30:0] > vam_pkg::HALF_PI_Q30) begin
			phi = vam_pkg::HALF_PI_Q30;
		end else begin
			phi = d.z[30:0];
		end
		if (d.quad.yzero) begin
			a_full = d.quad.xneg ? vam_pkg::PI_Q30 : 33'd0;
		end else if (d.quad.xzero) begin
			a_full = d.quad.yneg ? vam_pkg::PI_Q30 + 33'(vam_pkg::HALF_PI_Q30)
			                     : 33'(vam_pkg::HALF_PI_Q30);
		end else if (!d.quad.xneg && !d.quad.yneg) begin
			a_full = 33'(phi);
		end else if (d.quad.xneg && !d.quad.yneg) begin
			a_full = vam_pkg::PI_Q30 - 33'(phi);
		end else if (d.quad.xneg) begin
			a_full = vam_pkg::PI_Q30 + 33'(phi);
		end else begin
			a_full = vam_pkg::TWO_PI_Q30 - 33'(phi);
		end
	end

	assign rsum  = {1'b0, a_s1} + 34'h10000;
	assign r17   = rsum[33:17];
	assign tot   = {1'b0, ph_s2, 17'b0} + 63'(pl_s2) + (63'd1 << 45);
	assign d17   = tot[62:46];
	assign deg_v = (d17 >= vam_pkg::FULL_DEG) ? 16'(d17 - vam_pkg::FULL_DEG) : d17[15:0];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1   <= a_full;
			mag_s1 <= d.sq.root[15:0] + 16'(d.sq.rem > d.sq.root);
		end
		if (en[1]) begin
			rad_s2 <= (r17 >= vam_pkg::FULL_RAD) ? 16'(r17 - vam_pkg::FULL_RAD) : r17[15:0];
			ph_s2  <= 45'(a_s1[32:17]) * 45'(vam_pkg::DEG_SCALE);
			pl_s2  <= 46'(a_s1[16:0]) * 46'(vam_pkg::DEG_SCALE);
			mag_s2 <= mag_s1;
		end
		if (en[2]) begin
			angle_s3 <= deg ? deg_v : rad_s2;
			mag_s3   <= mag_s2;
		end
	end

endmodule
`default_nettype wire
